FILE: design/fph_pkg.sv
package fph_pkg;

  localparam int BIN_COUNT     = 8;
  localparam int BIN_W         = 3;
  localparam int DIR_COUNT     = 2;
  localparam int CNT_NUM       = 2 * DIR_COUNT * BIN_COUNT;
  localparam int CNT_IDX_W     = 5;
  localparam int DEF_COUNTER_W = 32;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int LEN_W   = 16;
  localparam int TS_W    = 63;
  localparam int GAP_W   = 32;
  localparam int VALUE_W = 32;

  // input tdata: new_flow, payload_length, from_source, timestamp
  localparam int IN_FIELDS_W = 1 + LEN_W + 1 + TS_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // output tdata: size_bin, gap_bin, gap_counted, ignored, counter_index, counter_value
  localparam int OUT_FIELDS_W = 2 * BIN_W + 2 + CNT_IDX_W + VALUE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CNT_IDX_W-1:0] LAST_INDEX = CNT_IDX_W'(CNT_NUM - 1);

  localparam logic MODE_PACKET  = 1'b0;
  localparam logic MODE_READOUT = 1'b1;

  localparam logic KIND_SIZE = 1'b0;
  localparam logic KIND_GAP  = 1'b1;

  // work item handed from the front end to the back end
  typedef struct packed {
    logic             readout;
    logic             new_flow;
    logic             ignored;
    logic             dir;
    logic [BIN_W-1:0] size_bin;
    logic [BIN_W-1:0] gap_bin;
    logic             gap_counted;
  } cmd_t;

  // log2 binning: under 16 is bin 0, over 1023 is the top bin
  function automatic logic [BIN_W-1:0] bin_of(input logic [GAP_W-1:0] v);
    logic [BIN_W-1:0] b;
    if (v < GAP_W'(16)) begin
      b = '0;
    end else if (v > GAP_W'(1023)) begin
      b = BIN_W'(BIN_COUNT - 1);
    end else if (v[9]) begin
      b = 3'd6;
    end else if (v[8]) begin
      b = 3'd5;
    end else if (v[7]) begin
      b = 3'd4;
    end else if (v[6]) begin
      b = 3'd3;
    end else if (v[5]) begin
      b = 3'd2;
    end else begin
      b = 3'd1;
    end
    return b;
  endfunction

endpackage

FILE: design/fph_front.sv
module fph_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fph_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data,
  input  logic                            full,
  output logic                            push,
  output fph_pkg::cmd_t                   cmd
);

  logic                          include_zeros;
  logic [fph_pkg::TS_W-1:0]      last_time [fph_pkg::DIR_COUNT];
  logic [fph_pkg::TS_W-1:0]      last_time_next [fph_pkg::DIR_COUNT];

  logic                          new_flow;
  logic [fph_pkg::LEN_W-1:0]     payload_length;
  logic                          from_source;
  logic [fph_pkg::TS_W-1:0]      timestamp;
  logic                          dir;
  logic [fph_pkg::TS_W-1:0]      prev_time;
  logic [fph_pkg::GAP_W-1:0]     gap;
  logic                          drop;

  assign new_flow       = s_tdata[0];
  assign payload_length = s_tdata[fph_pkg::LEN_W:1];
  assign from_source    = s_tdata[fph_pkg::LEN_W+1];
  assign timestamp      = s_tdata[fph_pkg::LEN_W+1+fph_pkg::TS_W:fph_pkg::LEN_W+2];

  assign s_tready  = !full;
  assign cfg_ready = 1'b1;
  assign push      = s_tvalid && !full;

  assign dir       = !from_source;
  // a new flow sees both timestamps as already cleared
  assign prev_time = new_flow ? '0 : last_time[dir];
  assign gap       = fph_pkg::GAP_W'(timestamp[fph_pkg::GAP_W-1:0] -
                                     prev_time[fph_pkg::GAP_W-1:0]);
  assign drop      = (payload_length == '0) && !include_zeros;

  always_comb begin
    cmd             = '0;
    cmd.readout     = (s_tuser == fph_pkg::MODE_READOUT);
    cmd.new_flow    = new_flow;
    cmd.ignored     = drop;
    cmd.dir         = dir;
    if (!drop) begin
      cmd.size_bin    = fph_pkg::bin_of(fph_pkg::GAP_W'(payload_length));
      cmd.gap_counted = (prev_time != '0) && (gap != '1);
      if (cmd.gap_counted) begin
        cmd.gap_bin = fph_pkg::bin_of(gap);
      end
    end
  end

  always_comb begin
    last_time_next = last_time;
    if (push && s_tuser == fph_pkg::MODE_PACKET) begin
      if (new_flow) begin
        for (int i = 0; i < fph_pkg::DIR_COUNT; i++) begin
          last_time_next[i] = '0;
        end
      end
      if (!drop) begin
        last_time_next[dir] = timestamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      include_zeros <= 1'b0;
      for (int i = 0; i < fph_pkg::DIR_COUNT; i++) begin
        last_time[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        include_zeros <= cfg_data;
      end
      last_time <= last_time_next;
    end
  end

endmodule

FILE: design/fph_queue.sv
module fph_queue #(
  parameter int DEPTH = fph_pkg::DEF_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fph_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output fph_pkg::cmd_t rd_cmd,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fph_pkg::cmd_t     slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full   = (fill == CNT_W'(DEPTH));
  assign empty  = (fill == '0);
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: design/fph_back.sv
module fph_back #(
  parameter int COUNTER_WIDTH = fph_pkg::DEF_COUNTER_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fph_pkg::cmd_t                   cmd,
  input  logic                            empty,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fph_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast
);

  logic [COUNTER_WIDTH-1:0]        cnt      [fph_pkg::CNT_NUM];
  logic [COUNTER_WIDTH-1:0]        cnt_next [fph_pkg::CNT_NUM];

  logic                            rd_active;
  logic [fph_pkg::CNT_IDX_W-1:0]   rd_idx;

  logic [fph_pkg::BIN_W-1:0]       size_bin;
  logic [fph_pkg::BIN_W-1:0]       gap_bin;
  logic                            gap_counted;
  logic                            ignored;
  logic [fph_pkg::CNT_IDX_W-1:0]   counter_index;
  logic [fph_pkg::VALUE_W-1:0]     counter_value;

  logic                            out_free;
  logic                            start_rd;
  logic                            do_pkt;
  logic                            emit_rd;
  logic [fph_pkg::CNT_IDX_W-1:0]   sel_idx;
  logic [63:0]                     sel_wide;
  logic [fph_pkg::CNT_IDX_W-1:0]   size_hit;
  logic [fph_pkg::CNT_IDX_W-1:0]   gap_hit;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = !rd_active && out_free && !empty;
  assign start_rd = pop && cmd.readout;
  assign do_pkt   = pop && !cmd.readout;
  assign emit_rd  = (rd_active && out_free) || start_rd;
  assign sel_idx  = rd_active ? rd_idx : '0;
  assign sel_wide = 64'(cnt[sel_idx]);

  // counter layout: direction, then size/gap, then bin
  assign size_hit = {cmd.dir, fph_pkg::KIND_SIZE, cmd.size_bin};
  assign gap_hit  = {cmd.dir, fph_pkg::KIND_GAP, cmd.gap_bin};

  always_comb begin
    for (int i = 0; i < fph_pkg::CNT_NUM; i++) begin
      cnt_next[i] = cnt[i];
      if (do_pkt) begin
        if (cmd.new_flow) begin
          cnt_next[i] = '0;
        end
        if (!cmd.ignored &&
            (fph_pkg::CNT_IDX_W'(i) == size_hit ||
             (cmd.gap_counted && fph_pkg::CNT_IDX_W'(i) == gap_hit))) begin
          if (cnt_next[i] != '1) begin
            cnt_next[i] = cnt_next[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fph_pkg::CNT_NUM; i++) begin
        cnt[i] <= '0;
      end
      rd_active <= 1'b0;
      rd_idx    <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (emit_rd) begin
        rd_idx    <= sel_idx + 1'b1;
        rd_active <= (sel_idx != fph_pkg::LAST_INDEX);
        m_tvalid  <= 1'b1;
      end else if (do_pkt) begin
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_rd) begin
      size_bin      <= '0;
      gap_bin       <= '0;
      gap_counted   <= 1'b0;
      ignored       <= 1'b0;
      counter_index <= sel_idx;
      counter_value <= sel_wide[fph_pkg::VALUE_W-1:0];
      m_tlast       <= (sel_idx == fph_pkg::LAST_INDEX);
    end else if (do_pkt) begin
      size_bin      <= cmd.size_bin;
      gap_bin       <= cmd.gap_bin;
      gap_counted   <= cmd.gap_counted;
      ignored       <= cmd.ignored;
      counter_index <= '0;
      counter_value <= '0;
      m_tlast       <= 1'b1;
    end
  end

  assign m_tdata = fph_pkg::OUT_TDATA_W'({counter_value, counter_index, ignored,
                                          gap_counted, gap_bin, size_bin});

endmodule

FILE: design/flow_packet_log_histogram.sv
// path: a request is written into a queue slot and its result is registered in
//   the back end's output register; the front keeps filling the queue in a readout
// throughput: one packet request per cycle while the queue has room and the output
//   is not stalled; a readout holds the back end over 32 counters, one per cycle
// reset: clears all counters, both timestamps, include_zeros and the queue
module flow_packet_log_histogram #(
  parameter int COUNTER_WIDTH = fph_pkg::DEF_COUNTER_W,
  parameter int QUEUE_DEPTH   = fph_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // new_flow, payload_length[15:0], from_source, timestamp[62:0], zero pad
  input  logic [fph_pkg::IN_TDATA_W-1:0]  s_tdata,
  // mode
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // size_bin[2:0], gap_bin[2:0], gap_counted, ignored, counter_index[4:0],
  // counter_value[31:0], zero pad
  output logic [fph_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);

  fph_pkg::cmd_t push_cmd;
  fph_pkg::cmd_t pop_cmd;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  fph_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .full      (full),
    .push      (push),
    .cmd       (push_cmd)
  );

  fph_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (push_cmd),
    .full   (full),
    .pop    (pop),
    .rd_cmd (pop_cmd),
    .empty  (empty)
  );

  fph_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (pop_cmd),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: test/flow_packet_log_histogram_check.sv
`timescale 1ns / 100ps

module flow_packet_log_histogram_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // new_flow, payload_length[15:0], from_source, timestamp[62:0], zero pad
  input  logic [fph_pkg::IN_TDATA_W-1:0]  s_tdata,
  // mode
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // size_bin[2:0], gap_bin[2:0], gap_counted, ignored, counter_index[4:0],
  // counter_value[31:0], zero pad
  input  logic [fph_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            cfg_data,
  output int                              mismatches,
  output int                              outstanding
);

  localparam int LEN_LSB = 1;
  localparam int SRC_BIT = LEN_LSB + fph_pkg::LEN_W;
  localparam int TS_LSB  = SRC_BIT + 1;

  typedef struct {
    logic [fph_pkg::BIN_W-1:0]     size_bin;
    logic [fph_pkg::BIN_W-1:0]     gap_bin;
    logic                          gap_counted;
    logic                          ignored;
    logic [fph_pkg::CNT_IDX_W-1:0] counter_index;
    logic [fph_pkg::VALUE_W-1:0]   counter_value;
    logic                          last;
  } hist_result_t;

  hist_result_t awaited_results[$];
  logic [fph_pkg::VALUE_W-1:0] len_hist [2*fph_pkg::BIN_COUNT];
  logic [fph_pkg::VALUE_W-1:0] gap_hist [2*fph_pkg::BIN_COUNT];
  logic [63:0]                 prev_stamp [fph_pkg::DIR_COUNT];
  logic                        count_zeros;
  int                          result_no;

  function automatic logic [fph_pkg::BIN_W-1:0] log2_bin(
      input logic [fph_pkg::GAP_W-1:0] v);
    int msb;
    msb = 0;
    if (v < 16) return '0;
    if (v > 1023) return fph_pkg::BIN_W'(fph_pkg::BIN_COUNT - 1);
    for (int i = 0; i < 10; i++) if (v[i]) msb = i;
    return fph_pkg::BIN_W'(msb - 3);
  endfunction

  function automatic logic [fph_pkg::VALUE_W-1:0] sat_bump(
      input logic [fph_pkg::VALUE_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  task automatic clear_flow();
    for (int i = 0; i < 2*fph_pkg::BIN_COUNT; i++) begin
      len_hist[i] = '0;
      gap_hist[i] = '0;
    end
    prev_stamp[0] = '0;
    prev_stamp[1] = '0;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t, result %0d: %s", $time, result_no, what);
  endtask

  task automatic predict_request(input logic readout,
                                 input logic [fph_pkg::IN_TDATA_W-1:0] d);
    hist_result_t r;
    logic [3:0]                  slot;
    logic [fph_pkg::LEN_W-1:0]   len;
    logic                        dir;
    logic [63:0]                 stamp;
    logic [fph_pkg::GAP_W-1:0]   gap;
    len   = d[SRC_BIT-1:LEN_LSB];
    dir   = ~d[SRC_BIT];
    stamp = 64'(d[TS_LSB+fph_pkg::TS_W-1:TS_LSB]);
    if (readout) begin
      // order: src sizes, src gaps, dst sizes, dst gaps
      for (int k = 0; k < fph_pkg::CNT_NUM; k++) begin
        slot = {k[4], k[2:0]};
        r = '{default: '0};
        r.counter_index = fph_pkg::CNT_IDX_W'(k);
        r.counter_value = k[3] ? gap_hist[slot] : len_hist[slot];
        r.last = (k == fph_pkg::CNT_NUM - 1);
        awaited_results.insert(awaited_results.size(), r);
      end
    end else begin
      if (d[0]) clear_flow();
      r = '{default: '0};
      r.last = 1'b1;
      if (len == 0 && !count_zeros) begin
        r.ignored = 1'b1;
      end else begin
        r.size_bin = log2_bin(fph_pkg::GAP_W'(len));
        len_hist[{dir, r.size_bin}] = sat_bump(len_hist[{dir, r.size_bin}]);
        if (prev_stamp[dir] != 0) begin
          gap = fph_pkg::GAP_W'(stamp - prev_stamp[dir]);
          // an all-ones gap is treated as no gap
          if (gap != '1) begin
            r.gap_bin = log2_bin(gap);
            r.gap_counted = 1'b1;
            gap_hist[{dir, r.gap_bin}] = sat_bump(gap_hist[{dir, r.gap_bin}]);
          end
        end
        prev_stamp[dir] = stamp;
      end
      awaited_results.insert(awaited_results.size(), r);
    end
  endtask

  task automatic check_result(input logic [fph_pkg::OUT_TDATA_W-1:0] d, input logic lst);
    hist_result_t w;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with no request pending");
    end else begin
      w = awaited_results.pop_front();
      if (d[2:0] !== w.size_bin)
        report_mismatch($sformatf("size_bin %0d, want %0d", d[2:0], w.size_bin));
      if (d[5:3] !== w.gap_bin)
        report_mismatch($sformatf("gap_bin %0d, want %0d", d[5:3], w.gap_bin));
      if (d[6] !== w.gap_counted)
        report_mismatch($sformatf("gap_counted %b, want %b", d[6], w.gap_counted));
      if (d[7] !== w.ignored)
        report_mismatch($sformatf("ignored %b, want %b", d[7], w.ignored));
      if (d[12:8] !== w.counter_index)
        report_mismatch($sformatf("counter_index %0d, want %0d", d[12:8], w.counter_index));
      if (d[44:13] !== w.counter_value)
        report_mismatch($sformatf("counter_value %0d, want %0d", d[44:13], w.counter_value));
      if (lst !== w.last)
        report_mismatch($sformatf("tlast %b, want %b", lst, w.last));
    end
    result_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_flow();
      count_zeros = 1'b0;
      awaited_results.delete();
    end else begin
      if (m_tvalid === 1'b1 && m_tready) check_result(m_tdata, m_tlast);
      if (cfg_valid && cfg_ready === 1'b1) count_zeros = cfg_data;
      if (s_tvalid && s_tready === 1'b1)
        predict_request(s_tuser == fph_pkg::MODE_READOUT, s_tdata);
    end
    outstanding <= awaited_results.size();
  end

endmodule

FILE: test/flow_packet_log_histogram_test.sv
`timescale 1ns / 100ps

module flow_packet_log_histogram_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 62;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  // new_flow, payload_length[15:0], from_source, timestamp[62:0], zero pad
  logic [fph_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  // mode
  logic                            s_tuser = fph_pkg::MODE_PACKET;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // size_bin[2:0], gap_bin[2:0], gap_counted, ignored, counter_index[4:0],
  // counter_value[31:0], zero pad
  logic [fph_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_data = 1'b0;

  int mismatches;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  logic [fph_pkg::TS_W-1:0] flow_clock [2];

  flow_packet_log_histogram dut (.*);
  flow_packet_log_histogram_check checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input logic mode, input logic nf,
                              input logic [fph_pkg::LEN_W-1:0] len,
                              input logic src, input logic [fph_pkg::TS_W-1:0] ts);
    while ($urandom_range(99, 0) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= fph_pkg::IN_TDATA_W'({ts, src, len, nf});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold off new requests until every result is out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_zero_policy(input logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [fph_pkg::LEN_W-1:0] rand_length();
    int shift;
    shift = $urandom_range(fph_pkg::LEN_W, 0);
    return fph_pkg::LEN_W'($urandom & ((32'd1 << shift) - 1));
  endfunction

  function automatic logic [fph_pkg::TS_W-1:0] rand_stamp();
    return fph_pkg::TS_W'({$urandom, $urandom});
  endfunction

  task automatic send_random();
    int roll;
    logic src;
    logic [fph_pkg::TS_W-1:0] step;
    roll = $urandom_range(99, 0);
    src = 1'($urandom_range(1, 0));
    if (roll < 8) begin
      send_request(fph_pkg::MODE_READOUT, 1'($urandom_range(1, 0)),
                   fph_pkg::LEN_W'($urandom), src, rand_stamp());
    end else if (roll < 14) begin
      // out-of-order or zero stamps
      send_request(fph_pkg::MODE_PACKET, 1'($urandom_range(1, 0)), rand_length(), src,
                   ($urandom_range(3, 0) == 0) ? '0 : rand_stamp());
    end else begin
      if ($urandom_range(19, 0) == 0)
        step = fph_pkg::TS_W'({$urandom_range(1, 0), $urandom});
      else step = fph_pkg::TS_W'($urandom & ((32'd1 << $urandom_range(12, 0)) - 1));
      flow_clock[src] = flow_clock[src] + step;
      send_request(fph_pkg::MODE_PACKET, roll < 17, rand_length(), src, flow_clock[src]);
    end
  endtask

  initial begin
    flow_clock[0] = fph_pkg::TS_W'($urandom) + 1'b1;
    flow_clock[1] = fph_pkg::TS_W'({$urandom_range(255, 1), $urandom});
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // counters fresh out of reset
    send_request(fph_pkg::MODE_READOUT, 1'b0, '0, 1'b0, '0);
    // zero-length packet dropped, new flow still clears
    send_request(fph_pkg::MODE_PACKET, 1'b1, 16'd0, 1'b1, 63'd50);
    // source side: bin edges of size and gap
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd15, 1'b1, 63'd100);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd16, 1'b1, 63'd115);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd31, 1'b1, 63'd131);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd32, 1'b1, 63'd163);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd1023, 1'b1, 63'd1186);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd1024, 1'b1, 63'd2210);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'hFFFF, 1'b1, 63'd2722);
    // gap of all ones is not counted, a backward step wraps
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd64, 1'b1, 63'd2721);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd128, 1'b1, 63'd2621);
    // reverse side: zero stamp means no earlier packet
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd256, 1'b0, 63'd0);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd512, 1'b0, 63'd1000);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd200, 1'b0, '1);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd0, 1'b0, 63'd7);
    // readout leaves state alone even with new_flow set
    send_request(fph_pkg::MODE_READOUT, 1'b1, 16'hFFFF, 1'b1, '1);
    send_request(fph_pkg::MODE_PACKET, 1'b1, 16'd100, 1'b0, 63'd5);
    send_request(fph_pkg::MODE_READOUT, 1'b0, '0, 1'b0, '0);
    set_zero_policy(1'b1);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd0, 1'b1, 63'd10);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd0, 1'b1, 63'd27);
    send_request(fph_pkg::MODE_PACKET, 1'b0, 16'd0, 1'b0, 63'd6);
    send_request(fph_pkg::MODE_READOUT, 1'b0, '0, 1'b0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      set_zero_policy(phase[0]);
      idle_pct  = (phase == 1) ? 53 : (phase == 3) ? 24 : 0;
      stall_pct = (phase == 2) ? 53 : (phase == 3) ? 24 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) drain();
        send_random();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
